[src/rqd_pkg.sv]
// Shared types and codes for the ready queue deque.
// Used by rqd_cell, ready_queue_deque_core and rqd_checker; depends on nothing.
`timescale 1ns / 1ps

package rqd_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int OCC_W         = 7;

    typedef enum logic [2:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_REMOVE     = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } status_t;

    // One stored burst record.
    typedef struct packed {
        logic [7:0]  thread_index;
        logic [15:0] burst_index;
        logic [15:0] burst_length;
        logic [31:0] created_time;
    } rec_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  thread_index;
        logic [15:0] burst_index;
        logic [15:0] burst_length;
        logic [31:0] created_time;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       out_thread_index;
        logic [15:0]      out_burst_index;
        logic [15:0]      out_burst_length;
        logic [31:0]      out_created_time;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    // Per-cycle commands broadcast to every cell.
    typedef struct packed {
        logic capture;
        logic push_back;
        logic push_front;
        logic pop_front;
        logic remove;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } state_t;

endpackage

[src/rqd_cell.sv]
// One queue cell: holds a record and its match flag, trades records with neighbors.
// Depends on rqd_pkg.
`timescale 1ns / 1ps

module rqd_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  rqd_pkg::cell_ctl_t ctl,
    input  logic               valid,
    input  logic               is_back,
    input  logic               is_tail,
    input  rqd_pkg::rec_t      cmp_rec,
    input  rqd_pkg::rec_t      load_rec,
    input  rqd_pkg::rec_t      left_rec,
    input  rqd_pkg::rec_t      right_rec,
    input  logic               hit_in,
    output rqd_pkg::rec_t      rec,
    output logic               hit_out,
    output rqd_pkg::rec_t      tail_rec
);

    rqd_pkg::rec_t rec_reg;
    rqd_pkg::rec_t rec_next;
    logic          hit_reg;
    logic          hit_incl;

    // A match here or in any cell closer to the front.
    assign hit_incl = hit_in | hit_reg;
    assign hit_out  = hit_incl;
    assign rec      = rec_reg;
    assign tail_rec = is_tail ? rec_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            hit_reg <= valid && (cmp_rec == rec_reg);
        end
    end

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.push_back && is_back)
        begin
            rec_next = load_rec;
        end
        else if (ctl.push_front)
        begin
            rec_next = left_rec;
        end
        else if (ctl.pop_front || (ctl.remove && hit_incl))
        begin
            // close up toward the front
            rec_next = right_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

[src/ready_queue_deque_core.sv]
// Top level of the ready queue deque: control, cell row and result register.
// Depends on rqd_pkg and rqd_cell.
`timescale 1ns / 1ps

// Usage
//   Request channel: drive request and raise start; a transfer happens at a
//   rising edge where start is high and busy is low. All cells compare their
//   record with the request at that same edge.
//   Result channel: done is high for exactly one cycle with the result; the
//   receiver cannot stall and must take it in that cycle.
// Timing
//   Transfer moves control to the update state; at the edge ending it, cells
//   update and the result is registered, with done shown in the cycle after.
//   busy is high for the single update cycle, and no request is taken while
//   busy; in it the front-to-back match chain and the tail readout settle.
// Organization
//   Cell 0 holds the front record, cell occupancy-1 the back. Push front and
//   pop front shift the whole row; a matched removal shifts only the cells
//   from the match onward.
// Reset
//   Clears occupancy, control, done and the cells' match flags; cell records
//   are left as they are and are never read before being written.
module ready_queue_deque_core #(
    parameter int QUEUE_DEPTH = rqd_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rqd_pkg::req_t request,
    output logic          done,
    output rqd_pkg::rsp_t result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rqd_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    rqd_pkg::req_t      req_reg;
    rqd_pkg::rsp_t      result_reg, result_next;
    logic               done_reg;
    logic               accept;
    logic               full, empty, found;
    rqd_pkg::rec_t      req_rec, cmp_rec, tail_acc;
    rqd_pkg::cell_ctl_t ctl;

    rqd_pkg::rec_t cell_rec  [QUEUE_DEPTH];
    rqd_pkg::rec_t tail_rec  [QUEUE_DEPTH];
    logic          hit_chain [QUEUE_DEPTH+1];

    assign busy   = (state_reg == rqd_pkg::S_APPLY);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;
    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign found  = hit_chain[QUEUE_DEPTH];

    assign cmp_rec = '{request.thread_index, request.burst_index,
                       request.burst_length, request.created_time};
    assign req_rec = '{req_reg.thread_index, req_reg.burst_index,
                       req_reg.burst_length, req_reg.created_time};

    always_comb
    begin
        ctl            = '0;
        ctl.capture    = accept;
        if (busy)
        begin
            ctl.push_back  = (req_reg.action == rqd_pkg::ACT_PUSH_BACK) && !full;
            ctl.push_front = (req_reg.action == rqd_pkg::ACT_PUSH_FRONT) && !full;
            ctl.pop_front  = (req_reg.action == rqd_pkg::ACT_POP_FRONT) && !empty;
            ctl.remove     = (req_reg.action == rqd_pkg::ACT_REMOVE);
        end
    end

    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        rqd_pkg::rec_t left_rec, right_rec;

        if (i == 0)
        begin : g_first
            assign left_rec = req_rec;
        end
        else
        begin : g_mid
            assign left_rec = cell_rec[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_rec = cell_rec[i];
        end
        else
        begin : g_inner
            assign right_rec = cell_rec[i+1];
        end

        rqd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .valid     (CNT_W'(i) < count_reg),
            .is_back   (count_reg == CNT_W'(i)),
            .is_tail   (count_reg == CNT_W'(i + 1)),
            .cmp_rec   (cmp_rec),
            .load_rec  (req_rec),
            .left_rec  (left_rec),
            .right_rec (right_rec),
            .hit_in    (hit_chain[i]),
            .rec       (cell_rec[i]),
            .hit_out   (hit_chain[i+1]),
            .tail_rec  (tail_rec[i])
        );
    end

    // Only the tail cell can drive a nonzero record here.
    always_comb
    begin
        tail_acc = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            tail_acc = tail_acc | tail_rec[i];
        end
    end

    always_comb
    begin
        rqd_pkg::rec_t out_rec;
        rqd_pkg::status_t st;
        out_rec    = '0;
        st         = rqd_pkg::ST_OK;
        count_next = count_reg;
        state_next = state_reg;
        case (state_reg)
            rqd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = rqd_pkg::S_APPLY;
                end
            end
            rqd_pkg::S_APPLY:
            begin
                state_next = rqd_pkg::S_IDLE;
                case (req_reg.action)
                    rqd_pkg::ACT_PUSH_BACK, rqd_pkg::ACT_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            st = rqd_pkg::ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    rqd_pkg::ACT_POP_BACK:
                    begin
                        if (empty)
                        begin
                            st = rqd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            out_rec    = tail_acc;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    rqd_pkg::ACT_POP_FRONT:
                    begin
                        if (empty)
                        begin
                            st = rqd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            out_rec    = cell_rec[0];
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    rqd_pkg::ACT_REMOVE:
                    begin
                        if (found)
                        begin
                            // matched record equals the request fields
                            out_rec    = req_rec;
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            st = rqd_pkg::ST_NOMATCH;
                        end
                    end
                    default:
                    begin
                        st = rqd_pkg::ST_OK;
                    end
                endcase
            end
            default:
            begin
                state_next = rqd_pkg::S_IDLE;
            end
        endcase
        result_next = '{st, out_rec.thread_index, out_rec.burst_index,
                        out_rec.burst_length, out_rec.created_time,
                        rqd_pkg::OCC_W'(count_next)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rqd_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (busy)
        begin
            result_reg <= result_next;
        end
    end

endmodule

[src/rqd_checker.sv]
// Port-level checks for ready_queue_deque_core, attached by bind.
// Depends on rqd_pkg and the top level's port list.
`timescale 1ns / 1ps

module rqd_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input rqd_pkg::req_t request,
    input logic          done,
    input rqd_pkg::rsp_t result
);

    // A transfer occupies exactly one busy cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("transfer did not start the update cycle");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && done))
        else $error("update cycle not followed by one result");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != rqd_pkg::ST_OK)) |->
        (result.out_thread_index == '0 && result.out_burst_index == '0 &&
         result.out_burst_length == '0 && result.out_created_time == '0))
        else $error("record fields nonzero on a failed request");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == rqd_pkg::ST_EMPTY)) |-> (result.occupancy == '0))
        else $error("empty status with records held");

endmodule

bind ready_queue_deque_core rqd_checker u_rqd_checker (.*);

[tb/rqd_checker.sv]
// Checker for the ready queue deque: watches the request and result channels,
// predicts each result from its own copy of the queue and compares field by field.
// Depends on rqd_pkg.
`timescale 1ns / 1ps

module rqd_scoreboard #(
    parameter int QUEUE_DEPTH = rqd_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  rqd_pkg::req_t request,
    input  logic          done,
    input  rqd_pkg::rsp_t result,
    output int            errors,
    output int            pending,
    output int            checked,
    output int            full_hits,
    output int            empty_hits,
    output int            nomatch_hits,
    output int            match_hits
);

    rqd_pkg::rec_t held_records[$];     // front of the deque at index 0
    rqd_pkg::rsp_t awaited_results[$];  // oldest expectation at index 0

    int mismatches   = 0;
    int compared     = 0;
    int dropped_full = 0;
    int empty_pops   = 0;
    int misses       = 0;
    int removals     = 0;

    // Apply one request to the shadow deque and return the result it must give.
    function automatic rqd_pkg::rsp_t apply_request(rqd_pkg::req_t r);
        rqd_pkg::rec_t rec;
        rqd_pkg::rec_t taken;
        rqd_pkg::rsp_t rsp;
        bit   removed;
        int   hit;
        rec     = {r.thread_index, r.burst_index, r.burst_length, r.created_time};
        taken   = '0;
        rsp     = '0;
        removed = 1'b0;
        hit     = -1;
        rsp.status = rqd_pkg::ST_OK;
        case (r.action)
            rqd_pkg::ACT_PUSH_BACK, rqd_pkg::ACT_PUSH_FRONT:
            begin
                if (held_records.size() >= QUEUE_DEPTH)
                begin
                    rsp.status = rqd_pkg::ST_FULL;
                    dropped_full++;
                end
                else if (r.action == rqd_pkg::ACT_PUSH_BACK)
                    held_records.push_back(rec);
                else
                    held_records.push_front(rec);
            end
            rqd_pkg::ACT_POP_BACK, rqd_pkg::ACT_POP_FRONT:
            begin
                if (held_records.size() == 0)
                begin
                    rsp.status = rqd_pkg::ST_EMPTY;
                    empty_pops++;
                end
                else
                begin
                    if (r.action == rqd_pkg::ACT_POP_BACK)
                        taken = held_records.pop_back();
                    else
                        taken = held_records.pop_front();
                    removed = 1'b1;
                end
            end
            rqd_pkg::ACT_REMOVE:
            begin
                // first record from the front that equals the request
                for (int i = 0; i < held_records.size() && hit < 0; i++)
                    if (held_records[i] == rec)
                        hit = i;
                if (hit < 0)
                begin
                    rsp.status = rqd_pkg::ST_NOMATCH;
                    misses++;
                end
                else
                begin
                    taken = held_records[hit];
                    held_records.delete(hit);
                    removed = 1'b1;
                    removals++;
                end
            end
            default:
            begin
                // unused codes leave the queue alone
            end
        endcase
        if (removed)
        begin
            rsp.out_thread_index = taken.thread_index;
            rsp.out_burst_index  = taken.burst_index;
            rsp.out_burst_length = taken.burst_length;
            rsp.out_created_time = taken.created_time;
        end
        rsp.occupancy = rqd_pkg::OCC_W'(held_records.size());
        return rsp;
    endfunction

    function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
        if (want === got)
            return 1'b1;
        $display("%0t rqd_checker: %s mismatch, expected %0h, actual %0h",
                 $time, name, want, got);
        return 1'b0;
    endfunction

    always @(posedge clk)
    begin : watch
        rqd_pkg::rsp_t want;
        bit   ok;
        if (rst_n)
        begin
            // compare before predicting so a stray result is never masked
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t rqd_checker: result with nothing expected, expected none, actual %0h",
                             $time, result);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    ok = field_ok("status", 32'(want.status), 32'(result.status))
                       & field_ok("out_thread_index", 32'(want.out_thread_index),
                                  32'(result.out_thread_index))
                       & field_ok("out_burst_index", 32'(want.out_burst_index),
                                  32'(result.out_burst_index))
                       & field_ok("out_burst_length", 32'(want.out_burst_length),
                                  32'(result.out_burst_length))
                       & field_ok("out_created_time", want.out_created_time,
                                  result.out_created_time)
                       & field_ok("occupancy", 32'(want.occupancy), 32'(result.occupancy));
                    if (!ok)
                        mismatches++;
                    compared++;
                end
            end
            if (start && !busy)
                awaited_results.push_back(apply_request(request));
        end
        errors       <= mismatches;
        pending      <= awaited_results.size();
        checked      <= compared;
        full_hits    <= dropped_full;
        empty_hits   <= empty_pops;
        nomatch_hits <= misses;
        match_hits   <= removals;
    end

endmodule

[tb/tb.sv]
// Testbench top for ready_queue_deque_core: clock, reset, request stimulus
// and the final verdict. Depends on rqd_pkg, ready_queue_deque_core and rqd_scoreboard.
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_REQUESTS = 1150;
    localparam int PHASE_LEN       = 96;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int POOL_SIZE       = 16;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          start;
    logic          busy;
    rqd_pkg::req_t request;
    logic          done;
    rqd_pkg::rsp_t result;

    int errors;
    int pending;
    int checked;
    int full_hits;
    int empty_hits;
    int nomatch_hits;
    int match_hits;

    int            sent   = 0;
    int            cycles = 0;
    rqd_pkg::rec_t recent_pushes[POOL_SIZE];
    int            recent_count = 0;
    int            recent_wr    = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ready_queue_deque_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    rqd_scoreboard u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .done         (done),
        .result       (result),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked),
        .full_hits    (full_hits),
        .empty_hits   (empty_hits),
        .nomatch_hits (nomatch_hits),
        .match_hits   (match_hits)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t tb: timeout after %0d cycles, %0d results outstanding",
                     $time, cycles, pending);
            $display("tb: FAIL");
            $finish;
        end
    end

    // Hold the request until the transfer edge.
    task automatic send(input rqd_pkg::req_t r);
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    // Half the records come from a narrow value set so duplicates and hits are common.
    function automatic rqd_pkg::rec_t random_record();
        rqd_pkg::rec_t rec;
        if ($urandom_range(0, 1) == 0)
        begin
            rec.thread_index = 8'($urandom_range(0, 3));
            rec.burst_index  = 16'($urandom_range(0, 3));
            rec.burst_length = 16'($urandom_range(0, 1));
            rec.created_time = 32'($urandom_range(0, 3));
        end
        else
        begin
            rec.thread_index = 8'($urandom);
            rec.burst_index  = 16'($urandom);
            rec.burst_length = 16'($urandom);
            rec.created_time = $urandom;
        end
        return rec;
    endfunction

    // Phase 0 fills, 1 mixes, 2 drains, 3 leans on removals.
    function automatic rqd_pkg::req_t random_request(int phase);
        int unsigned   cut[5];
        int unsigned   p;
        logic [2:0]    act;
        rqd_pkg::rec_t rec;
        case (phase)
            0:       cut = '{45, 85, 90, 94, 98};
            1:       cut = '{25, 50, 62, 74, 96};
            2:       cut = '{5, 10, 45, 75, 98};
            default: cut = '{20, 35, 45, 55, 97};
        endcase
        p = $urandom_range(0, 99);
        if (p < cut[0])
            act = rqd_pkg::ACT_PUSH_BACK;
        else if (p < cut[1])
            act = rqd_pkg::ACT_PUSH_FRONT;
        else if (p < cut[2])
            act = rqd_pkg::ACT_POP_BACK;
        else if (p < cut[3])
            act = rqd_pkg::ACT_POP_FRONT;
        else if (p < cut[4])
            act = rqd_pkg::ACT_REMOVE;
        else
            act = 3'($urandom_range((1 << $bits(act)) - 1, int'(rqd_pkg::ACT_REMOVE) + 1));

        rec = random_record();
        if (act == rqd_pkg::ACT_PUSH_BACK || act == rqd_pkg::ACT_PUSH_FRONT)
        begin
            recent_pushes[recent_wr] = rec;
            recent_wr = (recent_wr + 1) % POOL_SIZE;
            if (recent_count < POOL_SIZE)
                recent_count++;
        end
        else if (act == rqd_pkg::ACT_REMOVE && recent_count > 0 && $urandom_range(0, 3) != 0)
        begin
            rec = recent_pushes[$urandom_range(0, recent_count - 1)];
            // flip one bit now and then for a near miss
            if ($urandom_range(0, 7) == 0)
                rec = rec ^ (rqd_pkg::rec_t'(1) << $urandom_range(0, $bits(rqd_pkg::rec_t) - 1));
        end
        return {act, rec};
    endfunction

    initial
    begin
        rqd_pkg::rec_t ones;
        rqd_pkg::rec_t zeros;
        rqd_pkg::rec_t pat_a;
        rqd_pkg::rec_t pat_b;
        bit            calm;

        ones  = '1;
        zeros = '0;
        pat_a = {8'hA5, 16'h5A5A, 16'hA5A5, 32'h5A5A_5A5A};
        pat_b = ~pat_a;

        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty queue and unused codes
        send({rqd_pkg::ACT_POP_BACK, zeros});
        send({rqd_pkg::ACT_POP_FRONT, ones});
        send({rqd_pkg::ACT_REMOVE, zeros});
        for (int k = 1; int'(rqd_pkg::ACT_REMOVE) + k < 8; k++)
            send({3'(int'(rqd_pkg::ACT_REMOVE) + k), ones});
        // build b, 0, ones, a, ones
        send({rqd_pkg::ACT_PUSH_BACK, ones});
        send({rqd_pkg::ACT_PUSH_FRONT, zeros});
        send({rqd_pkg::ACT_PUSH_BACK, pat_a});
        send({rqd_pkg::ACT_PUSH_FRONT, pat_b});
        send({rqd_pkg::ACT_PUSH_BACK, ones});
        // duplicate: the one nearer the front goes first
        send({rqd_pkg::ACT_REMOVE, ones});
        send({rqd_pkg::ACT_REMOVE, ones ^ rqd_pkg::rec_t'(1)});
        send({rqd_pkg::ACT_REMOVE, ones});
        send({rqd_pkg::ACT_REMOVE, zeros});
        send({3'(int'(rqd_pkg::ACT_REMOVE) + 1), pat_a});
        send({rqd_pkg::ACT_POP_BACK, ones});
        send({rqd_pkg::ACT_POP_FRONT, zeros});
        send({rqd_pkg::ACT_POP_FRONT, zeros});
        send({rqd_pkg::ACT_REMOVE, pat_a});

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // no gaps at all in this stretch
            calm = (n >= 400 && n < 650);
            if (!calm && $urandom_range(0, 99) < 21)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            send(random_request((n / PHASE_LEN) % 4));
        end
        start <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("tb: %0d requests sent, %0d results checked, %0d mismatching",
                 sent, checked, errors);
        $display("tb: %0d pushes dropped on full, %0d empty pops, %0d removals hit, %0d missed",
                 full_hits, empty_hits, match_hits, nomatch_hits);
        if (pending != 0)
            $display("tb: %0d expected results never arrived", pending);
        if (errors == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
